// ----- design/sdsch_pkg.sv -----
// Shared types and constants for the SCAN disk scheduler.
`default_nettype none
package sdsch_pkg;

    localparam int MAX_REQUESTS = 32;
    localparam int TRK_W        = 16;
    localparam int TC_W         = TRK_W + 1;
    localparam int DIST_W       = TRK_W + 1;
    localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
    localparam int REQ_AW       = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int PADDR_W      = 4;
    localparam int PDATA_W      = 32;
    localparam int REG_IDX_W    = 2;

    localparam logic [REG_IDX_W-1:0] REG_HEAD_START  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_TRACK_COUNT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_SWEEP_LEFT  = 2'd2;

    localparam logic [TC_W-1:0] TC_RESET = TC_W'(2 ** TRK_W);
    localparam logic [TC_W-1:0] TC_MIN   = TC_W'(2);
    localparam logic [TC_W-1:0] TC_MAX   = TC_W'(2 ** TRK_W);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE
    } sched_state_t;

    typedef struct packed {
        logic clear;
        logic sample;
        logic above;
    } pick_ctrl_t;

    typedef struct packed {
        logic              found;
        logic [REQ_AW-1:0] idx;
        logic [TRK_W-1:0]  val;
    } pick_res_t;

endpackage
`default_nettype wire

// ----- design/sdsch_ram.sv -----
// Generic single-port-write, registered-read RAM.
`default_nettype none
module sdsch_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

// ----- design/sdsch_pick.sv -----
// Running best-candidate selector fed by one store entry per cycle while sample is set.
`default_nettype none
module sdsch_pick (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire sdsch_pkg::pick_ctrl_t         ctrl,
    input  wire logic [sdsch_pkg::TRK_W-1:0]   rd_data,
    input  wire logic [sdsch_pkg::REQ_AW-1:0]  rd_idx,
    input  wire logic                          rd_served,
    input  wire logic [sdsch_pkg::TRK_W-1:0]   top_trk,
    input  wire logic [sdsch_pkg::TRK_W-1:0]   start_trk,
    output sdsch_pkg::pick_res_t               res
);

    logic                          found_reg, found_next;
    logic [sdsch_pkg::REQ_AW-1:0]  idx_reg, idx_next;
    logic [sdsch_pkg::TRK_W-1:0]   val_reg, val_next;
    logic [sdsch_pkg::TRK_W-1:0]   sat_trk;
    logic                          eligible;
    logic                          better;

    always_comb
    begin
        // saturate to the top track before comparing
        sat_trk  = (rd_data > top_trk) ? top_trk : rd_data;
        eligible = !rd_served && ((sat_trk >= start_trk) == ctrl.above);
        // strict compare keeps the earliest arrival among equal tracks
        better   = !found_reg || (ctrl.above ? (sat_trk < val_reg) : (sat_trk > val_reg));

        found_next = found_reg;
        idx_next   = idx_reg;
        val_next   = val_reg;
        priority if (ctrl.clear)
        begin
            found_next = 1'b0;
        end
        else if (ctrl.sample && eligible && better)
        begin
            found_next = 1'b1;
            idx_next   = rd_idx;
            val_next   = sat_trk;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        val_reg <= val_next;
    end

    assign res.found = found_reg;
    assign res.idx   = idx_reg;
    assign res.val   = val_reg;

endmodule
`default_nettype wire

// ----- design/scan_disk_scheduler.sv -----
// SCAN disk scheduler: request store, sweep sequencer and result registers.
// Loading: one request per cycle while busy is low; the final request starts a batch.
// Each result takes a store pass (one store read per stored request), a drain state and
// a decision state; the first strobe is registered after the first decision.
// A batch keeps busy high from its final transfer until the decision on its last visit.
// Reset restores register defaults and clears the batch; store contents stay undefined.
`default_nettype none
module scan_disk_scheduler (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [sdsch_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [sdsch_pkg::PDATA_W-1:0]   pwdata,
    output logic      [sdsch_pkg::PDATA_W-1:0]   prdata,
    output logic                                 pready,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [sdsch_pkg::TRK_W-1:0]     request_track,
    input  wire logic                            final_request,
    output logic                                 result_valid,
    output logic      [sdsch_pkg::TRK_W-1:0]     track,
    output logic      [sdsch_pkg::DIST_W-1:0]    total_distance,
    output logic                                 is_turnaround,
    output logic                                 final_result,
    output logic                                 overflow_flag
);

    sdsch_pkg::sched_state_t state_reg, state_next;

    logic [sdsch_pkg::TRK_W-1:0]        head_start_reg;
    logic [sdsch_pkg::TC_W-1:0]         track_count_reg;
    logic                               sweep_left_reg;

    logic [sdsch_pkg::CNT_W-1:0]        count_reg, count_next;
    logic                               overflow_reg, overflow_next;
    logic [sdsch_pkg::MAX_REQUESTS-1:0] served_reg, served_next;
    logic [sdsch_pkg::CNT_W-1:0]        idx_reg, idx_next;
    logic [sdsch_pkg::CNT_W-1:0]        emit_cnt_reg, emit_cnt_next;
    logic                               phase_reg, phase_next;
    logic [sdsch_pkg::TRK_W-1:0]        top_reg, top_next;
    logic [sdsch_pkg::TRK_W-1:0]        start_reg, start_next;
    logic                               left_reg, left_next;
    logic [sdsch_pkg::TRK_W-1:0]        head_reg, head_next;
    logic [sdsch_pkg::DIST_W-1:0]       dist_reg, dist_next;
    logic                               rd_vld_reg;
    logic [sdsch_pkg::REQ_AW-1:0]       rd_idx_reg;

    logic                               res_vld_reg, res_vld_next;
    logic [sdsch_pkg::TRK_W-1:0]        res_trk_reg, res_trk_next;
    logic [sdsch_pkg::DIST_W-1:0]       res_dist_reg, res_dist_next;
    logic                               res_turn_reg, res_turn_next;
    logic                               res_last_reg, res_last_next;
    logic                               res_ovf_reg, res_ovf_next;

    logic                               accept;
    logic                               cfg_write;
    logic [sdsch_pkg::REG_IDX_W-1:0]    cfg_idx;
    logic [sdsch_pkg::TRK_W-1:0]        top_calc;
    logic [sdsch_pkg::TRK_W-1:0]        start_calc;
    logic                               mem_we;
    logic                               rd_en;
    logic [sdsch_pkg::TRK_W-1:0]        rd_data;
    logic                               scan_end;
    logic                               emit;
    logic                               last;
    logic [sdsch_pkg::TRK_W-1:0]        emit_trk;
    logic [sdsch_pkg::TRK_W-1:0]        step;
    sdsch_pkg::pick_ctrl_t              pick_ctrl;
    sdsch_pkg::pick_res_t               pick_res;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[sdsch_pkg::PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            sdsch_pkg::REG_HEAD_START:  prdata = sdsch_pkg::PDATA_W'(head_start_reg);
            sdsch_pkg::REG_TRACK_COUNT: prdata = sdsch_pkg::PDATA_W'(track_count_reg);
            sdsch_pkg::REG_SWEEP_LEFT:  prdata = sdsch_pkg::PDATA_W'(sweep_left_reg);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_start_reg  <= '0;
            track_count_reg <= sdsch_pkg::TC_RESET;
            sweep_left_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                sdsch_pkg::REG_HEAD_START:  head_start_reg  <= pwdata[sdsch_pkg::TRK_W-1:0];
                sdsch_pkg::REG_TRACK_COUNT: track_count_reg <= pwdata[sdsch_pkg::TC_W-1:0];
                sdsch_pkg::REG_SWEEP_LEFT:  sweep_left_reg  <= pwdata[0];
                default:                    ;
            endcase
        end
    end

    // clamp the track count, then the start position
    always_comb
    begin
        priority if (track_count_reg < sdsch_pkg::TC_MIN)
        begin
            top_calc = sdsch_pkg::TRK_W'(1);
        end
        else if (track_count_reg > sdsch_pkg::TC_MAX)
        begin
            top_calc = {sdsch_pkg::TRK_W{1'b1}};
        end
        else
        begin
            top_calc = sdsch_pkg::TRK_W'(track_count_reg - sdsch_pkg::TC_W'(1));
        end
        start_calc = (head_start_reg > top_calc) ? top_calc : head_start_reg;
    end

    assign accept = start && (state_reg == sdsch_pkg::ST_LOAD);
    assign mem_we = accept && (count_reg < sdsch_pkg::CNT_W'(sdsch_pkg::MAX_REQUESTS));

    sdsch_ram #(
        .WIDTH (sdsch_pkg::TRK_W),
        .DEPTH (sdsch_pkg::MAX_REQUESTS)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (count_reg[sdsch_pkg::REQ_AW-1:0]),
        .wdata (request_track),
        .re    (rd_en),
        .raddr (idx_reg[sdsch_pkg::REQ_AW-1:0]),
        .rdata (rd_data)
    );

    sdsch_pick u_pick (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (pick_ctrl),
        .rd_data   (rd_data),
        .rd_idx    (rd_idx_reg),
        .rd_served (served_reg[rd_idx_reg]),
        .top_trk   (top_reg),
        .start_trk (start_reg),
        .res       (pick_res)
    );

    assign scan_end = ((idx_reg + sdsch_pkg::CNT_W'(1)) == count_reg);
    // after the turnaround there is nothing left to visit when no request is found
    assign emit     = pick_res.found || !phase_reg;
    assign last     = (emit_cnt_reg == count_reg);
    assign emit_trk = pick_res.found ? pick_res.val :
                      (left_reg ? '0 : top_reg);
    assign step     = (head_reg >= emit_trk) ? (head_reg - emit_trk) : (emit_trk - head_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            sdsch_pkg::ST_LOAD:
            begin
                if (accept && final_request)
                begin
                    state_next = sdsch_pkg::ST_SCAN;
                end
            end
            sdsch_pkg::ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = sdsch_pkg::ST_DRAIN;
                end
            end
            sdsch_pkg::ST_DRAIN:
            begin
                state_next = sdsch_pkg::ST_DECIDE;
            end
            sdsch_pkg::ST_DECIDE:
            begin
                if (!emit || last)
                begin
                    state_next = sdsch_pkg::ST_LOAD;
                end
                else
                begin
                    state_next = sdsch_pkg::ST_SCAN;
                end
            end
            default:
            begin
                state_next = sdsch_pkg::ST_LOAD;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        busy             = 1'b1;
        rd_en            = 1'b0;
        pick_ctrl.clear  = 1'b0;
        pick_ctrl.sample = rd_vld_reg;
        pick_ctrl.above  = left_reg ~^ phase_reg;
        unique case (state_reg)
            sdsch_pkg::ST_LOAD:
            begin
                busy            = 1'b0;
                pick_ctrl.clear = accept && final_request;
            end
            sdsch_pkg::ST_SCAN:
            begin
                rd_en = 1'b1;
            end
            sdsch_pkg::ST_DRAIN:
            begin
                rd_en = 1'b0;
            end
            sdsch_pkg::ST_DECIDE:
            begin
                pick_ctrl.clear = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // batch datapath
    always_comb
    begin
        count_next    = count_reg;
        overflow_next = overflow_reg;
        served_next   = served_reg;
        idx_next      = idx_reg;
        emit_cnt_next = emit_cnt_reg;
        phase_next    = phase_reg;
        top_next      = top_reg;
        start_next    = start_reg;
        left_next     = left_reg;
        head_next     = head_reg;
        dist_next     = dist_reg;
        res_vld_next  = 1'b0;
        res_trk_next  = res_trk_reg;
        res_dist_next = res_dist_reg;
        res_turn_next = res_turn_reg;
        res_last_next = res_last_reg;
        res_ovf_next  = res_ovf_reg;

        if (accept)
        begin
            if (mem_we)
            begin
                count_next = count_reg + sdsch_pkg::CNT_W'(1);
            end
            else
            begin
                overflow_next = 1'b1;
            end
            if (final_request)
            begin
                idx_next      = '0;
                emit_cnt_next = '0;
                phase_next    = 1'b0;
                top_next      = top_calc;
                start_next    = start_calc;
                left_next     = sweep_left_reg;
                head_next     = start_calc;
                dist_next     = '0;
            end
        end

        if (state_reg == sdsch_pkg::ST_SCAN)
        begin
            idx_next = idx_reg + sdsch_pkg::CNT_W'(1);
        end

        if (state_reg == sdsch_pkg::ST_DECIDE)
        begin
            idx_next = '0;
            if (emit)
            begin
                dist_next     = dist_reg + sdsch_pkg::DIST_W'(step);
                head_next     = emit_trk;
                emit_cnt_next = emit_cnt_reg + sdsch_pkg::CNT_W'(1);
                res_vld_next  = 1'b1;
                res_trk_next  = emit_trk;
                res_dist_next = dist_reg + sdsch_pkg::DIST_W'(step);
                res_turn_next = !pick_res.found;
                res_last_next = last;
                res_ovf_next  = overflow_reg;
                if (pick_res.found)
                begin
                    served_next[pick_res.idx] = 1'b1;
                end
                else
                begin
                    phase_next = 1'b1;
                end
            end
            if (!emit || last)
            begin
                count_next    = '0;
                overflow_next = 1'b0;
                served_next   = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= sdsch_pkg::ST_LOAD;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
            served_reg   <= '0;
            idx_reg      <= '0;
            emit_cnt_reg <= '0;
            phase_reg    <= 1'b0;
            head_reg     <= '0;
            dist_reg     <= '0;
            rd_vld_reg   <= 1'b0;
            res_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
            served_reg   <= served_next;
            idx_reg      <= idx_next;
            emit_cnt_reg <= emit_cnt_next;
            phase_reg    <= phase_next;
            head_reg     <= head_next;
            dist_reg     <= dist_next;
            rd_vld_reg   <= rd_en;
            res_vld_reg  <= res_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg      <= top_next;
        start_reg    <= start_next;
        left_reg     <= left_next;
        rd_idx_reg   <= idx_reg[sdsch_pkg::REQ_AW-1:0];
        res_trk_reg  <= res_trk_next;
        res_dist_reg <= res_dist_next;
        res_turn_reg <= res_turn_next;
        res_last_reg <= res_last_next;
        res_ovf_reg  <= res_ovf_next;
    end

    assign result_valid   = res_vld_reg;
    assign track          = res_trk_reg;
    assign total_distance = res_dist_reg;
    assign is_turnaround  = res_turn_reg;
    assign final_result   = res_last_reg;
    assign overflow_flag  = res_ovf_reg;

endmodule
`default_nettype wire

// ----- design/sdsch_chk.sv -----
// Port-level checker for the SCAN disk scheduler, bound to the top level.
`default_nettype none
module sdsch_chk (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic final_request,
    input wire logic result_valid,
    input wire logic final_result
);

    // results come only out of a running batch
    a_result_in_batch: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (busy || $past(busy)))
        else $error("result strobe outside a batch");

    // each result needs a fresh store pass
    a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("results on back-to-back cycles");

    // the last visit ends the batch
    a_final_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && final_result) |-> !busy)
        else $error("block still busy after final visit");

    // a non-final transfer only loads
    a_load_only: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && !final_request) |=> (!busy && !result_valid))
        else $error("non-final transfer started scheduling");

    // a final transfer starts scheduling
    a_final_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && final_request) |=> busy)
        else $error("final transfer did not start scheduling");

endmodule

bind scan_disk_scheduler sdsch_chk u_sdsch_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .final_request (final_request),
    .result_valid  (result_valid),
    .final_result  (final_result)
);
`default_nettype wire

// ----- sim/tb_scan_disk_scheduler.sv -----
`timescale 1ns / 100ps
// Testbench for the SCAN disk scheduler: queued request driver, visit predictor and checker.
module tb_scan_disk_scheduler;

    import sdsch_pkg::*;

    localparam int PERIOD      = 20;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_GOAL = 180;
    localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [TRK_W-1:0] trk;
        logic             last;
    } request_t;

    typedef struct packed {
        logic [TRK_W-1:0]  trk;
        logic [DIST_W-1:0] dist_total;
        logic              turn;
        logic              last;
        logic              ovf;
    } visit_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               start = 1'b0;
    logic               busy;
    logic [TRK_W-1:0]   request_track = '0;
    logic               final_request = 1'b0;
    logic               result_valid;
    logic [TRK_W-1:0]   track;
    logic [DIST_W-1:0]  total_distance;
    logic               is_turnaround;
    logic               final_result;
    logic               overflow_flag;

    scan_disk_scheduler dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .start          (start),
        .busy           (busy),
        .request_track  (request_track),
        .final_request  (final_request),
        .result_valid   (result_valid),
        .track          (track),
        .total_distance (total_distance),
        .is_turnaround  (is_turnaround),
        .final_result   (final_result),
        .overflow_flag  (overflow_flag)
    );

    // register shadows
    logic [TRK_W-1:0] cfg_head_start = '0;
    logic [TC_W-1:0]  cfg_track_count = TC_RESET;
    logic             cfg_sweep_left = 1'b0;

    // predictor state
    logic [TRK_W-1:0]  req_store [MAX_REQUESTS];
    int unsigned       req_count = 0;
    logic              ovf_seen = 1'b0;
    logic [TRK_W-1:0]  head_pos = '0;
    logic [DIST_W-1:0] dist_sum = '0;

    request_t    request_q[$];
    visit_t      expected_visits[$];
    visit_t      due;
    request_t    cur_request;
    logic        item_taken = 1'b0;
    bit          steady_sender = 1'b0;
    int          burst_left = 0;
    int          gap_left = 0;
    int          mismatch_count = 0;
    int          cycle_count = 0;
    logic [TRK_W-1:0] last_drawn = '0;

    always #(PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic logic [TRK_W-1:0] top_track();
        logic [TC_W-1:0] tc;
        tc = cfg_track_count;
        if (tc < TC_MIN)
            tc = TC_MIN;
        if (tc > TC_MAX)
            tc = TC_MAX;
        return TRK_W'(tc - 1'b1);
    endfunction

    function automatic logic [TRK_W-1:0] sweep_origin();
        logic [TRK_W-1:0] top;
        top = top_track();
        return (cfg_head_start > top) ? top : cfg_head_start;
    endfunction

    task automatic flag_mismatch(input string what);
        if (mismatch_count < 50)
            $display("%0t ns mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic add_visit(input logic [TRK_W-1:0] trk, input logic turn, input logic last);
        visit_t            v;
        logic [DIST_W-1:0] step;
        step = (head_pos > trk) ? DIST_W'(head_pos - trk) : DIST_W'(trk - head_pos);
        dist_sum = dist_sum + step;
        head_pos = trk;
        v.trk        = trk;
        v.dist_total = dist_sum;
        v.turn       = turn;
        v.last       = last;
        v.ovf        = ovf_seen;
        expected_visits.push_back(v);
    endtask

    // Build the whole service order of the loaded batch.
    task automatic plan_sweep();
        logic [TRK_W-1:0] top;
        logic [TRK_W-1:0] origin;
        logic [TRK_W-1:0] sat;
        logic [TRK_W-1:0] best_val;
        int               best;
        int unsigned      total;
        int unsigned      n;
        bit               above;
        bit               served [MAX_REQUESTS];
        top = top_track();
        origin = sweep_origin();
        head_pos = origin;
        dist_sum = '0;
        total = req_count + 1;
        n = 0;
        best_val = '0;
        foreach (served[i])
            served[i] = 1'b0;
        for (int phase = 0; phase < 2; phase++)
        begin
            above = cfg_sweep_left ? (phase == 1) : (phase == 0);
            best = 0;
            while (best >= 0)
            begin
                best = -1;
                for (int i = 0; i < req_count; i++)
                begin
                    sat = (req_store[i] > top) ? top : req_store[i];
                    if (!served[i] && ((sat >= origin) == above))
                    begin
                        // strict compare keeps arrival order among equal tracks
                        if (best < 0 || (above ? sat < best_val : sat > best_val))
                        begin
                            best = i;
                            best_val = sat;
                        end
                    end
                end
                if (best >= 0)
                begin
                    served[best] = 1'b1;
                    add_visit(best_val, 1'b0, (n + 1) == total);
                    n++;
                end
            end
            if (phase == 0)
            begin
                add_visit(cfg_sweep_left ? '0 : top, 1'b1, (n + 1) == total);
                n++;
            end
        end
        req_count = 0;
        ovf_seen = 1'b0;
    endtask

    task automatic log_request(input logic [TRK_W-1:0] trk, input logic last);
        if (req_count < MAX_REQUESTS)
        begin
            req_store[req_count] = trk;
            req_count++;
        end
        else
            ovf_seen = 1'b1;
        if (last)
            plan_sweep();
    endtask

    function automatic logic [TRK_W-1:0] draw_track();
        logic [TRK_W-1:0] top;
        logic [TRK_W-1:0] origin;
        logic [TRK_W-1:0] pick;
        top = top_track();
        origin = sweep_origin();
        case ($urandom_range(0, 6))
            0, 1: pick = TRK_W'($urandom);
            2, 3: pick = TRK_W'($urandom_range(0, top));
            4: pick = origin + TRK_W'($urandom_range(0, 2)) - 1'b1;
            5:
            begin
                case ($urandom_range(0, 3))
                    0: pick = '0;
                    1: pick = top;
                    2: pick = top + 1'b1;
                    default: pick = '1;
                endcase
            end
            default: pick = last_drawn;
        endcase
        last_drawn = pick;
        return pick;
    endfunction

    task automatic add_request(input logic [TRK_W-1:0] trk, input logic last);
        request_t r;
        r.trk  = trk;
        r.last = last;
        request_q.push_back(r);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_HEAD_START:  cfg_head_start = value[TRK_W-1:0];
            REG_TRACK_COUNT: cfg_track_count = value[TC_W-1:0];
            REG_SWEEP_LEFT:  cfg_sweep_left = value[0];
            default: ;
        endcase
    endtask

    // Hold until every request is transferred and every visit has come back.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (request_q.size() != 0 || start || expected_visits.size() != 0 || busy);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_config(input logic [TRK_W-1:0] head, input logic [TC_W-1:0] tc,
                                input logic left);
        write_reg(REG_HEAD_START, PDATA_W'(head));
        write_reg(REG_TRACK_COUNT, PDATA_W'(tc));
        write_reg(REG_SWEEP_LEFT, PDATA_W'(left));
    endtask

    // driver: one request per transfer, bursts separated by random gaps
    always @(negedge clk)
    begin
        logic start_next;
        if (rst_n)
        begin
            start_next = start;
            if (item_taken)
            begin
                item_taken = 1'b0;
                start_next = 1'b0;
            end
            if (!start_next && request_q.size() != 0)
            begin
                if (gap_left != 0)
                    gap_left--;
                else
                begin
                    cur_request = request_q.pop_front();
                    request_track <= cur_request.trk;
                    final_request <= cur_request.last;
                    start_next = 1'b1;
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 16);
                        if (steady_sender || $urandom_range(0, 2) == 0)
                            gap_left = 0;
                        else
                            gap_left = $urandom_range(1, 5);
                    end
                    else
                        burst_left--;
                end
            end
            start <= start_next;
        end
    end

    // monitor: predict on each request transfer, check each visit
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
            begin
                log_request(request_track, final_request);
                item_taken = 1'b1;
            end
            if (result_valid)
            begin
                if (expected_visits.size() == 0)
                    flag_mismatch($sformatf("visit to track %0d with none expected", track));
                else
                begin
                    due = expected_visits.pop_front();
                    if (track !== due.trk)
                        flag_mismatch($sformatf("track got %0d want %0d", track, due.trk));
                    if (total_distance !== due.dist_total)
                        flag_mismatch($sformatf("total_distance got %0d want %0d (track %0d)",
                                                total_distance, due.dist_total, due.trk));
                    if (is_turnaround !== due.turn)
                        flag_mismatch($sformatf("is_turnaround got %b want %b (track %0d)",
                                                is_turnaround, due.turn, due.trk));
                    if (final_result !== due.last)
                        flag_mismatch($sformatf("final_result got %b want %b (track %0d)",
                                                final_result, due.last, due.trk));
                    if (overflow_flag !== due.ovf)
                        flag_mismatch($sformatf("overflow_flag got %b want %b (track %0d)",
                                                overflow_flag, due.ovf, due.trk));
                end
            end
        end
    end

    initial
    begin
        int random_items;
        int phase_no;
        int phase_items;
        int len;
        logic [TRK_W-1:0] head;
        logic [TC_W-1:0]  tc;
        random_items = 0;
        phase_no = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: sweep up from track 0, duplicates and both extremes
        add_request(16'h8000, 1'b0);
        add_request(16'h0000, 1'b0);
        add_request(16'hFFFF, 1'b0);
        add_request(16'h8000, 1'b0);
        add_request(16'h0001, 1'b0);
        add_request(16'd100, 1'b1);
        wait_idle();

        // sweep down from mid disk, requests on both sides of the head
        write_config(16'd30000, TC_MAX, 1'b1);
        add_request(16'd29999, 1'b0);
        add_request(16'd30000, 1'b0);
        add_request(16'h0000, 1'b0);
        add_request(16'hFFFF, 1'b0);
        add_request(16'd12, 1'b0);
        add_request(16'd30001, 1'b1);
        wait_idle();

        // track count below the minimum: the head and every request above track 1 saturate to it
        write_config(16'hFFFF, '0, 1'b0);
        add_request(16'h0000, 1'b0);
        add_request(16'h0001, 1'b0);
        add_request(16'hFFFF, 1'b0);
        add_request(16'd5, 1'b1);
        wait_idle();

        // track count above the maximum; a write past the register list is dropped
        write_reg(REG_TRACK_COUNT, PDATA_W'({TC_W{1'b1}}));
        write_reg(REG_SWEEP_LEFT, PDATA_W'(1));
        write_reg(REG_UNMAPPED, '1);
        add_request(16'h1234, 1'b1);
        wait_idle();

        write_config(16'h0000, TC_W'(1), 1'b1);
        add_request(16'hFFFF, 1'b1);
        wait_idle();

        // head on the top track sweeping up: serve the top-track requests, then turn
        write_config(16'hFFFF, TC_MAX, 1'b0);
        add_request(16'hFFFF, 1'b0);
        add_request(16'd40000, 1'b0);
        add_request(16'hFFFF, 1'b1);
        wait_idle();

        while (random_items < RANDOM_GOAL)
        begin
            case ($urandom_range(0, 3))
                0: head = '0;
                1: head = '1;
                default: head = TRK_W'($urandom);
            endcase
            case ($urandom_range(0, 5))
                0: tc = TC_W'($urandom_range(0, 3));
                1: tc = TC_MAX;
                2: tc = TC_W'($urandom_range(65537, 131071));
                3, 4: tc = TC_W'($urandom_range(2, 300));
                default: tc = TC_W'($urandom_range(2, 65536));
            endcase
            write_config(head, tc, 1'($urandom_range(0, 1)));
            steady_sender = (phase_no % 3 == 2);
            phase_items = 0;
            while (phase_items < 35)
            begin
                if (phase_no == 1 && phase_items == 0)
                    len = MAX_REQUESTS + 2;
                else if (phase_no == 2 && phase_items == 0)
                    len = MAX_REQUESTS;
                else if ($urandom_range(0, 11) == 0)
                    len = $urandom_range(MAX_REQUESTS - 2, MAX_REQUESTS + 4);
                else
                    len = $urandom_range(1, 8);
                for (int k = 0; k < len; k++)
                    add_request(draw_track(), k == len - 1);
                phase_items += len;
            end
            random_items += phase_items;
            phase_no++;
            wait_idle();
        end

        wait_idle();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
